[rtl/length_framed_command_receiver_defines.svh]
// Assertion macros for the frame receiver.
// Define ASSERT_OFF to compile the checks out.
`ifndef LENGTH_FRAMED_COMMAND_RECEIVER_DEFINES_SVH
`define LENGTH_FRAMED_COMMAND_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define LFCR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define LFCR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LFCR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LFCR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/lfcr_pkg.sv]
`default_nettype none

package lfcr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned RIDX_W    = 5;
    localparam int unsigned LIMIT_W   = 6;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned PHASE_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Fixed frame positions.
    localparam logic [POS_W-1:0] POS_HEAD = 6'd0;
    localparam logic [POS_W-1:0] POS_FUNC = 6'd1;
    localparam logic [POS_W-1:0] POS_LEN  = 6'd2;
    localparam logic [POS_W-1:0] ID_START = 6'd3;

    localparam logic [BYTE_W-1:0]  TOTAL_EXTRA     = 8'd4;
    localparam logic [BYTE_W-1:0]  HEADER_RESET    = 8'h00;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 6'd24;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE    = 2'd0,
        KIND_READ    = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER = 2'd0,
        REG_LIMIT  = 2'd1
    } t_reg_index;

endpackage

`default_nettype wire

[rtl/lfcr_if.sv]
`default_nettype none

interface lfcr_cmd_if;
    import lfcr_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] rx_byte;
    logic [RIDX_W-1:0] read_index;

    modport source (output valid, output kind, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input kind, input rx_byte, input read_index,
                    output ready);
endinterface

interface lfcr_rsp_if;
    import lfcr_pkg::*;
    logic               valid;
    logic               ready;
    logic               frame_ready;
    logic               byte_taken;
    logic [BYTE_W-1:0]  read_data;
    logic [BYTE_W-1:0]  frame_total;
    logic [PHASE_W-1:0] parser_phase;

    modport source (output valid, output frame_ready, output byte_taken,
                    output read_data, output frame_total, output parser_phase,
                    input ready);
    modport sink   (input valid, input frame_ready, input byte_taken,
                    input read_data, input frame_total, input parser_phase,
                    output ready);
endinterface

interface lfcr_cfg_if;
    import lfcr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [BYTE_W-1:0]    wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

[rtl/length_framed_command_receiver.sv]
// A result beat is registered and appears in the cycle after its command beat is accepted.
// One command beat per cycle while the result sink is not stalling; the frame store
// has one write port and one registered read port, and each beat uses at most one of them.
// Reset (synchronous, active low) clears the parser, ready flag, output valid
// and the registers (header 0, limit 24); the frame store is not cleared.
`default_nettype none
`include "length_framed_command_receiver_defines.svh"

module length_framed_command_receiver #(
    parameter int unsigned STORE_DEPTH = 32
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    lfcr_cmd_if.sink   i_cmd,
    lfcr_cfg_if.sink   i_cfg,
    lfcr_rsp_if.source o_rsp
);
    import lfcr_pkg::*;

    localparam int unsigned AW     = $clog2(STORE_DEPTH);
    localparam int unsigned WIDE_W = 9;
    localparam logic [WIDE_W-1:0] DEPTH_WIDE = WIDE_W'(STORE_DEPTH);

    typedef enum logic [PHASE_W-1:0] {
        PH_HEAD = 2'd0,
        PH_FUNC = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [BYTE_W-1:0]  r_total, n_total;
    logic               r_ready, n_ready;
    logic               r_taken, n_taken;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_header;
    logic [LIMIT_W-1:0] r_limit;
    logic [BYTE_W-1:0]  r_rd_data;

    logic [BYTE_W-1:0]  r_mem [STORE_DEPTH];

    logic               cmd_accept;
    logic               cfg_accept;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic               rd_hit;
    logic [WIDE_W-1:0]  pos_wide;
    logic [WIDE_W-1:0]  ridx_wide;
    logic [POS_W:0]     pos_inc;
    logic [BYTE_W-1:0]  len_total;

    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign i_cfg.ready = 1'b1;
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;
    assign cfg_accept  = i_cfg.valid && i_cfg.ready;

    assign pos_wide  = {{(WIDE_W-POS_W){1'b0}}, r_pos};
    assign ridx_wide = {{(WIDE_W-RIDX_W){1'b0}}, i_cmd.read_index};
    assign pos_inc   = {1'b0, r_pos} + {{POS_W{1'b0}}, 1'b1};
    assign len_total = i_cmd.rx_byte + TOTAL_EXTRA;
    assign mem_raddr = ridx_wide[AW-1:0];
    assign rd_hit    = (t_kind'(i_cmd.kind) == KIND_READ) && (ridx_wide < DEPTH_WIDE);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_total   = r_total;
        n_ready   = r_ready;
        n_taken   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = pos_wide[AW-1:0];
        case (t_kind'(i_cmd.kind))
            KIND_BYTE: begin
                // Drop bytes while a finished frame waits for release.
                if (!r_ready) begin
                    case (r_phase)
                        PH_HEAD: begin
                            if (i_cmd.rx_byte == r_header) begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(POS_HEAD);
                                n_phase   = PH_FUNC;
                                n_taken   = 1'b1;
                            end
                        end
                        PH_FUNC: begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(POS_FUNC);
                            n_phase   = PH_LEN;
                            n_taken   = 1'b1;
                        end
                        PH_LEN: begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(POS_LEN);
                            n_total   = len_total;
                            n_taken   = 1'b1;
                            // Abandon frames whose total reaches the limit.
                            if (len_total < {{(BYTE_W-LIMIT_W){1'b0}}, r_limit}) begin
                                n_pos   = ID_START;
                                n_phase = PH_DATA;
                            end else begin
                                n_phase = PH_HEAD;
                            end
                        end
                        PH_DATA: begin
                            if (pos_wide >= DEPTH_WIDE) begin
                                n_phase = PH_HEAD;
                            end else begin
                                mem_we  = 1'b1;
                                n_pos   = pos_inc[POS_W-1:0];
                                n_taken = 1'b1;
                                if ({{(BYTE_W-POS_W-1){1'b0}}, pos_inc} > r_total) begin
                                    n_ready = 1'b1;
                                    n_phase = PH_HEAD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            KIND_RELEASE: n_ready = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEAD;
            r_pos       <= '0;
            r_total     <= '0;
            r_ready     <= 1'b0;
            r_taken     <= 1'b0;
            r_out_valid <= 1'b0;
            r_header    <= HEADER_RESET;
            r_limit     <= LIMIT_RESET;
        end else begin
            if (cfg_accept) begin
                case (t_reg_index'(i_cfg.reg_index))
                    REG_HEADER: r_header <= i_cfg.wdata;
                    REG_LIMIT:  r_limit  <= i_cfg.wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd_accept) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_total     <= n_total;
                r_ready     <= n_ready;
                r_taken     <= n_taken;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame store: at most one write or one registered read per accepted beat.
    always_ff @(posedge i_clk) begin
        if (cmd_accept) begin
            if (mem_we) begin
                r_mem[mem_waddr] <= i_cmd.rx_byte;
            end
            if (rd_hit) begin
                r_rd_data <= r_mem[mem_raddr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.frame_ready  = r_ready;
    assign o_rsp.byte_taken   = r_taken;
    assign o_rsp.read_data    = r_rd_data;
    assign o_rsp.frame_total  = r_total;
    assign o_rsp.parser_phase = r_phase;

    `LFCR_ASSERT_IMP(a_ready_in_head, i_clk, i_rst_n, r_ready, r_phase == PH_HEAD, "ready flag up outside header phase")
    `LFCR_ASSERT_IMP(a_data_pos, i_clk, i_rst_n, r_phase == PH_DATA, r_pos >= ID_START, "payload position below ID start")
    `LFCR_ASSERT_NXT(a_drop_while_ready, i_clk, i_rst_n, cmd_accept && r_ready && (t_kind'(i_cmd.kind) == KIND_BYTE), !o_rsp.byte_taken, "byte taken while frame ready")
    `LFCR_ASSERT_NXT(a_read_zero, i_clk, i_rst_n, cmd_accept && (t_kind'(i_cmd.kind) != KIND_READ), o_rsp.read_data == '0, "read data nonzero for non-read beat")
    `LFCR_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, cmd_accept, o_rsp.valid, "no result beat after accepted command")

endmodule

`default_nettype wire
